### rtl/dbmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbmd_pkg
// Shared types, codes and helper functions for the backend message deframer.
// ----------------------------------------------------------------------------
package dbmd_pkg;

  // Frame type bytes (ASCII)
  localparam logic [7:0] TYPE_AUTH   = 8'h52; // 'R'
  localparam logic [7:0] TYPE_PARAM  = 8'h53; // 'S'
  localparam logic [7:0] TYPE_KEY    = 8'h4B; // 'K'
  localparam logic [7:0] TYPE_READY  = 8'h5A; // 'Z'
  localparam logic [7:0] TYPE_ROWDSC = 8'h54; // 'T'
  localparam logic [7:0] TYPE_DATROW = 8'h44; // 'D'
  localparam logic [7:0] TYPE_CLOSE  = 8'h43; // 'C'

  // Result kinds
  localparam logic [3:0] KIND_AUTH_OK    = 4'd0;
  localparam logic [3:0] KIND_KERBEROS   = 4'd1;
  localparam logic [3:0] KIND_CLEARTEXT  = 4'd2;
  localparam logic [3:0] KIND_GSS        = 4'd3;
  localparam logic [3:0] KIND_SSPI       = 4'd4;
  localparam logic [3:0] KIND_SASL       = 4'd5;
  localparam logic [3:0] KIND_SASL_CONT  = 4'd6;
  localparam logic [3:0] KIND_SASL_FINAL = 4'd7;
  localparam logic [3:0] KIND_PARAM      = 4'd8;
  localparam logic [3:0] KIND_KEY        = 4'd9;
  localparam logic [3:0] KIND_READY      = 4'd10;
  localparam logic [3:0] KIND_ROW_DESC   = 4'd11;
  localparam logic [3:0] KIND_DATA_ROW   = 4'd12;
  localparam logic [3:0] KIND_CLOSE      = 4'd13;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TYPE      = 3'd1;
  localparam logic [2:0] ERR_LENGTH    = 3'd2;
  localparam logic [2:0] ERR_TRUNC     = 3'd3;
  localparam logic [2:0] ERR_AUTH_BAD  = 3'd4;
  localparam logic [2:0] ERR_AUTH_NIMP = 3'd5;
  localparam logic [2:0] ERR_NO_TERM   = 3'd6;

  // Authentication subtypes
  localparam logic [31:0] AUTH_OK        = 32'd0;
  localparam logic [31:0] AUTH_KERBEROS  = 32'd2;
  localparam logic [31:0] AUTH_CLEARTEXT = 32'd3;
  localparam logic [31:0] AUTH_MD5       = 32'd5;
  localparam logic [31:0] AUTH_GSS       = 32'd7;
  localparam logic [31:0] AUTH_GSS_CONT  = 32'd8;
  localparam logic [31:0] AUTH_SSPI      = 32'd9;
  localparam logic [31:0] AUTH_SASL      = 32'd10;
  localparam logic [31:0] AUTH_SASL_CONT = 32'd11;
  localparam logic [31:0] AUTH_SASL_FIN  = 32'd12;

  // Length rules
  localparam logic [31:0] LEN_HDR       = 32'd4;
  localparam logic [31:0] LEN_AUTH_MIN  = 32'd8;
  localparam logic [31:0] LEN_PARAM_MIN = 32'd6;
  localparam logic [31:0] LEN_KEY       = 32'd12;
  localparam logic [31:0] LEN_READY     = 32'd5;

  // One result transaction
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] frame_length;
    logic [31:0] auth_subtype;
    logic [7:0]  ready_status;
    logic [31:0] param_name_len;
    logic [2:0]  error_code;
  } dbmd_result_t;

  function automatic logic known_type(input logic [7:0] b);
    return b inside {TYPE_AUTH, TYPE_PARAM, TYPE_KEY, TYPE_READY,
                     TYPE_ROWDSC, TYPE_DATROW, TYPE_CLOSE};
  endfunction

  function automatic logic length_ok(input logic [7:0] t, input logic [31:0] len);
    logic ok;
    if (len < LEN_HDR) begin
      ok = 1'b0;
    end else begin
      case (t)
        TYPE_AUTH:  ok = (len >= LEN_AUTH_MIN);
        TYPE_PARAM: ok = (len >= LEN_PARAM_MIN);
        TYPE_KEY:   ok = (len == LEN_KEY);
        TYPE_READY: ok = (len == LEN_READY);
        default:    ok = 1'b1;
      endcase
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

### rtl/dbmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbmd_if
// Valid/ready channels of the deframer: received bytes in, frame results out.
// ----------------------------------------------------------------------------
interface dbmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface dbmd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] frame_length;
  logic [31:0] auth_subtype;
  logic [7:0]  ready_status;
  logic [31:0] param_name_len;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output frame_length, output auth_subtype,
                  output ready_status, output param_name_len, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input frame_length, input auth_subtype,
                  input ready_status, input param_name_len, input error_code,
                  output ready);
endinterface
`default_nettype wire

### rtl/dbmd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbmd_parser
// Frame state machine: walks type, length and payload bytes and forms the
// result of the current byte combinationally from held state and the byte.
// ----------------------------------------------------------------------------
module dbmd_parser
  import dbmd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         take,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_buffer,
  output logic              res_fire,
  output dbmd_result_t      res
);

  typedef enum logic [2:0] {
    PH_TYPE, PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_BODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        disc_r, disc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] body_r, body_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] sub_r, sub_nxt;
  logic [31:0] zidx_r, zidx_nxt;
  logic        zseen_r, zseen_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        done;
  logic [31:0] len_full;

  assign len_full = {length_r[23:0], data_byte};

  // Next state and result for the byte on the input
  always_comb begin
    phase_nxt  = phase_r;
    disc_nxt   = disc_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    body_nxt   = body_r;
    cnt_nxt    = cnt_r;
    sub_nxt    = sub_r;
    zidx_nxt   = zidx_r;
    zseen_nxt  = zseen_r;
    status_nxt = status_r;
    done       = 1'b0;
    res_fire   = 1'b0;
    res        = '0;

    if (!disc_r) begin
      case (phase_r)
        PH_TYPE: begin
          if (known_type(data_byte)) begin
            type_nxt   = data_byte;
            length_nxt = '0;
            cnt_nxt    = '0;
            sub_nxt    = '0;
            zidx_nxt   = '0;
            zseen_nxt  = 1'b0;
            status_nxt = '0;
            phase_nxt  = PH_LEN0;
          end else begin
            res_fire       = 1'b1;
            res.error_code = ERR_TYPE;
            disc_nxt       = 1'b1;
          end
        end
        PH_LEN0: begin
          length_nxt = len_full;
          phase_nxt  = PH_LEN1;
        end
        PH_LEN1: begin
          length_nxt = len_full;
          phase_nxt  = PH_LEN2;
        end
        PH_LEN2: begin
          length_nxt = len_full;
          phase_nxt  = PH_LEN3;
        end
        PH_LEN3: begin
          length_nxt = len_full;
          body_nxt   = len_full - LEN_HDR;
          if (!length_ok(type_r, len_full)) begin
            res_fire         = 1'b1;
            res.frame_length = len_full;
            res.error_code   = ERR_LENGTH;
            disc_nxt         = 1'b1;
            phase_nxt        = PH_TYPE;
          end else if (len_full == LEN_HDR) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (cnt_r < 32'd4) begin
            sub_nxt = {sub_r[23:0], data_byte};
          end
          if (cnt_r == '0) begin
            status_nxt = data_byte;
          end
          if (!zseen_r && (data_byte == 8'd0)) begin
            zseen_nxt = 1'b1;
            zidx_nxt  = cnt_r;
          end
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_nxt == body_r) begin
            done = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase
    end

    // Close the frame: classify by type
    if (done) begin
      phase_nxt        = PH_TYPE;
      res_fire         = 1'b1;
      res.frame_length = length_nxt;
      case (type_r)
        TYPE_AUTH: begin
          res.auth_subtype = sub_nxt;
          case (sub_nxt)
            AUTH_OK:        res.kind = KIND_AUTH_OK;
            AUTH_KERBEROS:  res.kind = KIND_KERBEROS;
            AUTH_CLEARTEXT: res.kind = KIND_CLEARTEXT;
            AUTH_GSS:       res.kind = KIND_GSS;
            AUTH_SSPI:      res.kind = KIND_SSPI;
            AUTH_SASL:      res.kind = KIND_SASL;
            AUTH_SASL_CONT: res.kind = KIND_SASL_CONT;
            AUTH_SASL_FIN:  res.kind = KIND_SASL_FINAL;
            AUTH_MD5, AUTH_GSS_CONT: begin
              res.error_code = ERR_AUTH_NIMP;
              disc_nxt       = 1'b1;
            end
            default: begin
              res.error_code = ERR_AUTH_BAD;
              disc_nxt       = 1'b1;
            end
          endcase
        end
        TYPE_PARAM: begin
          if (!zseen_nxt) begin
            res.error_code = ERR_NO_TERM;
            disc_nxt       = 1'b1;
          end else begin
            res.kind           = KIND_PARAM;
            res.param_name_len = zidx_nxt;
          end
        end
        TYPE_KEY:    res.kind = KIND_KEY;
        TYPE_READY: begin
          res.kind         = KIND_READY;
          res.ready_status = status_nxt;
        end
        TYPE_ROWDSC: res.kind = KIND_ROW_DESC;
        TYPE_DATROW: res.kind = KIND_DATA_ROW;
        default:     res.kind = KIND_CLOSE;
      endcase
    end

    // End of buffer: flag truncation, then rearm for a type byte
    if (end_of_buffer) begin
      if (!res_fire && !disc_r && (phase_nxt != PH_TYPE)) begin
        res_fire         = 1'b1;
        res              = '0;
        res.frame_length = (phase_nxt == PH_BODY) ? length_nxt : '0;
        res.error_code   = ERR_TRUNC;
      end
      phase_nxt = PH_TYPE;
      disc_nxt  = 1'b0;
    end
  end

  // Hold state, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      disc_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      disc_r  <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      type_r   <= type_nxt;
      length_r <= length_nxt;
      body_r   <= body_nxt;
      cnt_r    <= cnt_nxt;
      sub_r    <= sub_nxt;
      zidx_r   <= zidx_nxt;
      zseen_r  <= zseen_nxt;
      status_r <= status_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/dbmd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbmd_out_reg
// Result register: holds one result transaction until the sink takes it and
// reports whether a new one can be loaded in this cycle.
// ----------------------------------------------------------------------------
module dbmd_out_reg
  import dbmd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  dbmd_result_t       res,
  output logic               slot_free,
  dbmd_out_if.source         out_ch
);

  logic         valid_r, valid_nxt;
  dbmd_result_t res_r;

  // Slot is free when empty or drained in this cycle
  assign slot_free = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.frame_length   = res_r.frame_length;
  assign out_ch.auth_subtype   = res_r.auth_subtype;
  assign out_ch.ready_status   = res_r.ready_status;
  assign out_ch.param_name_len = res_r.param_name_len;
  assign out_ch.error_code     = res_r.error_code;

endmodule
`default_nettype wire

### rtl/db_backend_message_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// db_backend_message_deframer
// Splits a received backend byte stream into type/length/payload frames,
// checks each frame and reports its kind, or the first error of a buffer.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                         | Handshake
//  in_ch   | in  | data_byte[7:0], end_of_buffer                   | valid/ready
//  out_ch  | out | kind, frame_length, auth_subtype, ready_status, | valid/ready
//          |     | param_name_len, error_code                      |
//
//  One byte per cycle unless stalled; a result appears in the cycle after the
//  closing byte of a frame, set by the single register stage before out_ch.
//  Synchronous active-low reset returns to awaiting a type byte.
//  in_ch.ready drops only while a result is held and out_ch.ready is low.
// ----------------------------------------------------------------------------
module db_backend_message_deframer
  import dbmd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  dbmd_in_if.sink    in_ch,
  dbmd_out_if.source out_ch
);

  logic         take;
  logic         slot_free;
  logic         res_fire;
  dbmd_result_t res;

  assign in_ch.ready = slot_free;
  assign take        = in_ch.valid && slot_free;

  dbmd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_ch.data_byte),
    .end_of_buffer (in_ch.end_of_buffer),
    .res_fire      (res_fire),
    .res           (res)
  );

  dbmd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res_fire),
    .res       (res),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  // Error results carry kind zero
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.error_code != ERR_NONE)) |-> (out_ch.kind == KIND_AUTH_OK))
    else $error("error result with nonzero kind");

  // Truncation reports no decoded payload fields
  a_trunc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.error_code == ERR_TRUNC)) |->
      ((out_ch.auth_subtype == '0) && (out_ch.ready_status == '0) &&
       (out_ch.param_name_len == '0)))
    else $error("truncation result carries payload fields");

  // Name length only on a good parameter status result
  a_name_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.param_name_len != '0)) |->
      ((out_ch.kind == KIND_PARAM) && (out_ch.error_code == ERR_NONE)))
    else $error("name length outside parameter status");

  // A result held under backpressure blocks new input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

endmodule
`default_nettype wire
